// ===== sv/assert_macros.svh =====
// Assertion macros shared by the IR frame decoder RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define IRPFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define IRPFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== sv/irpfd_pkg.sv =====
// Shared types, constants and helper functions of the IR frame decoder.
// Has no dependencies; every other RTL file imports it.
`default_nettype none

package irpfd_pkg;

  localparam int unsigned TicksW       = 13;
  localparam int unsigned PulseW       = 16;
  // Twice the pulse length, and fifteen times the tick rate, both fit here.
  localparam int unsigned HalfW        = 17;
  localparam int unsigned PayloadW     = 9;
  localparam int unsigned PayloadWidth = 9;
  localparam int unsigned PosW         = 5;
  localparam int unsigned CountW       = 3;
  localparam int unsigned BitsW        = 4;

  localparam logic [TicksW-1:0] TicksPerMsReset = 13'd1000;

  localparam logic [PosW-1:0] PosIdle       = 5'd0;
  localparam logic [PosW-1:0] PosGap        = 5'd1;
  localparam logic [PosW-1:0] PosHeader     = 5'd2;
  localparam logic [PosW-1:0] PosSpaceFirst = 5'd3;
  localparam logic [PosW-1:0] PosLast       = 5'd21;

  localparam logic [BitsW-1:0] BitsFull = 4'd9;

  localparam logic [CountW-1:0] CountUnknown = 3'd0;
  localparam logic [CountW-1:0] CountFive    = 3'd1;
  localparam logic [CountW-1:0] CountSeven   = 3'd2;
  localparam logic [CountW-1:0] CountEight   = 3'd3;
  localparam logic [CountW-1:0] CountNine    = 3'd4;

  // Pulse bounds in half-milliseconds, scaled by the tick rate.
  typedef struct packed {
    logic [HalfW-1:0] h1;
    logic [HalfW-1:0] h3;
    logic [HalfW-1:0] h5;
    logic [HalfW-1:0] h7;
    logic [HalfW-1:0] h11;
    logic [HalfW-1:0] h13;
    logic [HalfW-1:0] h15;
  } bounds_t;

  typedef struct packed {
    logic [PulseW-1:0] ticks;
    logic              mark;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                beacon;
    logic [PayloadW-1:0] payload;
    logic [CountW-1:0]   code;
    logic                frame_ok;
  } result_t;

  function automatic logic [HalfW-1:0] bound_of(input logic [TicksW-1:0] ticks,
                                                input logic [3:0] k);
    return HalfW'(ticks) * HalfW'(k);
  endfunction

  function automatic bounds_t make_bounds(input logic [TicksW-1:0] ticks);
    bounds_t b;
    b.h1  = bound_of(ticks, 4'd1);
    b.h3  = bound_of(ticks, 4'd3);
    b.h5  = bound_of(ticks, 4'd5);
    b.h7  = bound_of(ticks, 4'd7);
    b.h11 = bound_of(ticks, 4'd11);
    b.h13 = bound_of(ticks, 4'd13);
    b.h15 = bound_of(ticks, 4'd15);
    return b;
  endfunction

  function automatic logic [CountW-1:0] count_code(input logic [BitsW-1:0] bits);
    logic [CountW-1:0] code;
    unique case (bits)
      4'd5:    code = CountFive;
      4'd7:    code = CountSeven;
      4'd8:    code = CountEight;
      4'd9:    code = CountNine;
      default: code = CountUnknown;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/irpfd_bounds.sv =====
// Tick-rate register of the IR frame decoder, held as precomputed pulse bounds.
// Depends on irpfd_pkg.
`default_nettype none

module irpfd_bounds import irpfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [TicksW-1:0] cfg_data_i,
  output logic              cfg_ready_o,
  output bounds_t           bounds_o
);

  bounds_t bounds_q, bounds_d;

  assign cfg_ready_o = 1'b1;

  // The constant multiples are worked out once per register write.
  always_comb begin
    bounds_d = bounds_q;
    if (cfg_valid_i) begin
      bounds_d = make_bounds(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= make_bounds(TicksPerMsReset);
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

`default_nettype wire

// ===== sv/irpfd_frame.sv =====
// Frame position tracker and bit shifter of the IR frame decoder.
// Depends on irpfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irpfd_frame import irpfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  bounds_t bounds_i,
  output result_t res_o
);

  logic [PosW-1:0]         pos_q, pos_d;
  logic                    kind_q, kind_d;
  logic [PayloadWidth-1:0] shift_q, shift_d;

  logic [HalfW-1:0] twice;
  logic             mark;
  logic             gt5;
  logic             w13, w35, w57, w1113, w1115;
  logic [PosW-1:0]  rel;
  logic [BitsW-1:0] bits;
  logic             finish;

  assign twice = {item_i.ticks, 1'b0};
  assign mark  = item_i.mark;

  // All windows are strict on both sides.
  assign gt5   = twice > bounds_i.h5;
  assign w13   = (twice > bounds_i.h1)  && (twice < bounds_i.h3);
  assign w35   = (twice > bounds_i.h3)  && (twice < bounds_i.h5);
  assign w57   = gt5                    && (twice < bounds_i.h7);
  assign w1113 = (twice > bounds_i.h11) && (twice < bounds_i.h13);
  assign w1115 = (twice > bounds_i.h11) && (twice < bounds_i.h15);

  assign rel = pos_q - PosSpaceFirst;

  always_comb begin
    pos_d   = pos_q;
    kind_d  = kind_q;
    shift_d = shift_q;
    bits    = rel[BitsW:1];
    finish  = 1'b0;
    if (en_i) begin
      if (pos_q == PosIdle) begin
        if (mark && w57) begin
          pos_d = PosGap;
        end
      end else if (pos_q == PosGap) begin
        pos_d = (!mark && w1115) ? PosHeader : PosIdle;
      end else if (pos_q == PosHeader) begin
        if (mark && w57) begin
          kind_d = 1'b0;
          pos_d  = PosSpaceFirst;
        end else if (mark && w1113) begin
          kind_d = 1'b1;
          pos_d  = PosSpaceFirst;
        end else begin
          pos_d = PosIdle;
        end
      end else if (pos_q == PosLast) begin
        pos_d = PosIdle;
        if (!mark && gt5) begin
          finish = 1'b1;
          bits   = BitsFull;
        end
      end else if (pos_q < PosLast) begin
        if (pos_q[0]) begin
          // Space slot: a short gap continues, a long one closes the frame, others drop it.
          if (!mark && w35) begin
            pos_d = pos_q + PosW'(1);
          end else begin
            pos_d  = PosIdle;
            finish = !mark && gt5;
          end
        end else begin
          if (mark && w13) begin
            shift_d = {shift_q[PayloadWidth-2:0], 1'b0};
            pos_d   = pos_q + PosW'(1);
          end else if (mark && w35) begin
            shift_d = {shift_q[PayloadWidth-2:0], 1'b1};
            pos_d   = pos_q + PosW'(1);
          end else begin
            pos_d = PosIdle;
          end
        end
      end else begin
        pos_d = PosIdle;
      end
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.valid    = finish;
    res_o.beacon   = kind_q;
    res_o.payload  = shift_q[PayloadW-1:0];
    res_o.code     = count_code(bits);
    res_o.frame_ok = res_o.code != CountUnknown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosIdle;
      kind_q  <= 1'b0;
      shift_q <= '0;
    end else begin
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      shift_q <= shift_d;
    end
  end

  `IRPFD_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PosLast)
  `IRPFD_ASSERT(a_end_on_space, clk_i, rst_ni, !res_o.valid || (en_i && !mark))
  `IRPFD_ASSERT_NEXT(a_end_rewinds, clk_i, rst_ni, res_o.valid, pos_q == PosIdle)

endmodule

`default_nettype wire

// ===== sv/ir_pulse_frame_decoder_core.sv =====
// Top level of the IR pulse-width frame decoder: input register, frame
// tracker and result register. Depends on irpfd_pkg, irpfd_bounds, irpfd_frame.
//
// Use: each input word is one measured IR interval (pulse_ticks_i, ir_present_i),
// offered with in_valid_i and taken at an edge where in_stall_o is low.
// A frame of header mark, header space, header kind mark and alternating
// data spaces and marks is tracked; a long space closes the frame and one
// result word (header_beacon_o, payload_o, bit_count_code_o, frame_valid_o)
// is offered on out_valid_o until taken at an edge where out_stall_i is low.
// Intervals that close no frame produce no result word.
// The tick rate is written through cfg_valid_i / cfg_data_i, always ready; the
// user writes it only while the decoder is idle; the block does not enforce this.
// Throughput: one word per cycle while no pending result is stalled. An
// accepted word is held in the input register, classified there once it may
// advance, and its result is then shown from the result register.
// When the receiver stalls with a result pending, the input register holds
// its word and in_stall_o rises; nothing is lost.
// Reset clears the frame position, header kind and bit register, sets the
// tick rate to 1000 per millisecond and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module ir_pulse_frame_decoder_core import irpfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TicksW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PulseW-1:0]   pulse_ticks_i,
  input  logic                ir_present_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                header_beacon_o,
  output logic [PayloadW-1:0] payload_o,
  output logic [CountW-1:0]   bit_count_code_o,
  output logic                frame_valid_o
);

  bounds_t bounds;
  result_t res;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;
  logic                beacon_q;
  logic [PayloadW-1:0] payload_q;
  logic [CountW-1:0]   code_q;
  logic                frame_ok_q;

  irpfd_bounds u_bounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .bounds_o    (bounds)
  );

  irpfd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .bounds_i (bounds),
    .res_o    (res)
  );

  // The held word moves on whenever the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.ticks <= pulse_ticks_i;
      item_q.mark  <= ir_present_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      beacon_q   <= res.beacon;
      payload_q  <= res.payload;
      code_q     <= res.code;
      frame_ok_q <= res.frame_ok;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign header_beacon_o  = beacon_q;
  assign payload_o        = payload_q;
  assign bit_count_code_o = code_q;
  assign frame_valid_o    = frame_ok_q;

  `IRPFD_ASSERT(a_ok_matches_code, clk_i, rst_ni,
                !out_valid_o || (frame_valid_o == (bit_count_code_o != CountUnknown)))
  `IRPFD_ASSERT(a_code_range, clk_i, rst_ni,
                !out_valid_o || (bit_count_code_o <= CountNine))
  `IRPFD_ASSERT_NEXT(a_take_fills, clk_i, rst_ni, in_take, in_valid_q)

endmodule

`default_nettype wire
